// ----- rtl/lagrange_coefficient_interpolation_assert.svh -----
// Assertion macros used by the checker file
`ifndef LAGRANGE_COEFFICIENT_INTERPOLATION_ASSERT_SVH
`define LAGRANGE_COEFFICIENT_INTERPOLATION_ASSERT_SVH

// same-cycle implication, disabled during reset
`define LCI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lci check failed");

// next-cycle implication, disabled during reset
`define LCI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lci check failed");

`endif

// ----- rtl/lci_pkg.sv -----
// Shared constants, types and modular helpers for the interpolation block
`timescale 1ns / 1ps
package lci_pkg;

   localparam int MAX_POINTS = 64;
   localparam int POW_BITS = 30;
   localparam logic [29:0] MODP = 30'd998244353;
   localparam logic [29:0] POW_EXP = 30'd998244351;
   localparam logic [31:0] MODP2 = 32'd1996488706;
   localparam logic [63:0] MU_WIDE = 64'd1152921504606846976 / 64'd998244353;
   localparam logic [30:0] MU = MU_WIDE[30:0];

   typedef enum logic [4:0] {
      ST_IDLE, ST_N_XI, ST_N_XILAT, ST_N_RD, ST_N_MUL, ST_N_WAIT,
      ST_W_XI, ST_W_XILAT, ST_W_RD, ST_W_MUL, ST_W_WAIT,
      ST_PW_R, ST_PW_RW, ST_PW_B, ST_PW_BW, ST_WT, ST_WT_W,
      ST_S_RD, ST_S_U, ST_S_UW, ST_S_W, ST_S_WW,
      ST_O_RD, ST_O_LOAD, ST_O_WAIT
   } lci_state_type;

   typedef enum logic [4:0] {
      OP_NONE, OP_STORE, OP_XI_LOAD, OP_NODE_MUL, OP_NODE_WB,
      OP_DIFF_MUL, OP_DIFF_WB, OP_POW_INIT, OP_POWR_MUL, OP_POWR_WB,
      OP_POWB_MUL, OP_POWB_WB, OP_WT_MUL, OP_WT_WB,
      OP_SYN_U_MUL, OP_SYN_U_WB, OP_SYN_W_MUL, OP_SYN_W_WB, OP_OUT_LOAD
   } lci_op_type;

   typedef enum logic [1:0] {
      OLDP_MEM, OLDP_ZERO, OLDP_ONE
   } lci_oldp_type;

   typedef struct packed {
      lci_op_type   op;
      logic         rd_en;
      logic [6:0]   addr;
      logic [5:0]   acc_addr;
      lci_oldp_type oldp_sel;
      logic         acc_zero;
      logic         out_last;
   } lci_cmd_type;

   typedef struct packed {
      logic mul_done;
   } lci_status_type;

   function automatic logic [29:0] add_mod(input logic [29:0] a, input logic [29:0] b);
      logic [30:0] s;
      s = {1'b0, a} + {1'b0, b};
      return (s >= {1'b0, MODP}) ? 30'(s - {1'b0, MODP}) : s[29:0];
   endfunction

   function automatic logic [29:0] sub_mod(input logic [29:0] a, input logic [29:0] b);
      logic [30:0] s;
      s = (a >= b) ? ({1'b0, a} - {1'b0, b}) : ({1'b0, a} + {1'b0, MODP} - {1'b0, b});
      return s[29:0];
   endfunction

   // inputs are below 2^30, so one subtract reaches the canonical residue
   function automatic logic [29:0] reduce_mod(input logic [29:0] a);
      return (a >= MODP) ? (a - MODP) : a;
   endfunction

endpackage

// ----- rtl/lci_mulmod.sv -----
// Four-stage Barrett modular multiplier for the prime modulus
`timescale 1ns / 1ps
module lci_mulmod (
   input  logic        clock,
   input  logic        reset,
   input  logic        start,
   input  logic [29:0] a,
   input  logic [29:0] b,
   output logic        done,
   output logic [29:0] result
);
   logic [3:0]  valid_ff, valid_in;
   logic [59:0] prod_ff, prod_in;
   logic [61:0] q_ff, q_in;
   logic [31:0] low_ff, low_in;
   logic [60:0] qp_full;
   logic [31:0] r_ff, r_in;
   logic [29:0] res_ff, res_in;

   assign prod_in  = a * b;
   assign q_in     = prod_ff[59:29] * lci_pkg::MU;
   assign low_in   = prod_ff[31:0];
   assign qp_full  = q_ff[61:31] * lci_pkg::MODP;
   // remainder estimate stays below three moduli
   assign r_in     = low_ff - qp_full[31:0];
   assign valid_in = {valid_ff[2:0], start};

   always_comb begin
      if (r_ff >= lci_pkg::MODP2) begin
         res_in = 30'(r_ff - lci_pkg::MODP2);
      end else if (r_ff >= {2'b0, lci_pkg::MODP}) begin
         res_in = 30'(r_ff - {2'b0, lci_pkg::MODP});
      end else begin
         res_in = r_ff[29:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      q_ff    <= q_in;
      low_ff  <= low_in;
      r_ff    <= r_in;
      res_ff  <= res_in;
   end

   assign done   = valid_ff[3];
   assign result = res_ff;
endmodule

// ----- rtl/lci_datapath.sv -----
// Datapath: point stores, polynomial memories, working registers, multiplier
`timescale 1ns / 1ps
module lci_datapath (
   input  logic                    clock,
   input  logic                    reset,
   input  lci_pkg::lci_cmd_type    cmd,
   output lci_pkg::lci_status_type status,
   input  logic [29:0]             x_value,
   input  logic [29:0]             y_value,
   output logic [29:0]             coefficient,
   output logic [5:0]              power_index,
   output logic                    last_coefficient
);
   logic [29:0] x_mem_ff [lci_pkg::MAX_POINTS];
   logic [29:0] y_mem_ff [lci_pkg::MAX_POINTS];
   logic [29:0] p_mem_ff [lci_pkg::MAX_POINTS + 1];
   logic [29:0] a_mem_ff [lci_pkg::MAX_POINTS];

   logic [29:0] rd_x_ff, rd_y_ff, rd_p_ff, rd_a_ff;
   logic [29:0] xi_ff, yi_ff, d_ff, base_ff, r_ff, w_ff, u_ff, prev_ff, oldp_ff;
   logic [29:0] coef_ff;
   logic [5:0]  pidx_ff;
   logic        last_ff;

   logic [29:0] oldp, acc_old, mul_a, mul_b, mul_res;
   logic        mul_start, mul_done;

   always_comb begin
      case (cmd.oldp_sel)
         lci_pkg::OLDP_ZERO: oldp = '0;
         lci_pkg::OLDP_ONE:  oldp = 30'd1;
         default:            oldp = rd_p_ff;
      endcase
   end

   assign acc_old = cmd.acc_zero ? '0 : rd_a_ff;

   always_comb begin
      mul_start = 1'b1;
      mul_a     = r_ff;
      mul_b     = base_ff;
      case (cmd.op)
         lci_pkg::OP_NODE_MUL: begin
            mul_a = oldp;
            mul_b = xi_ff;
         end
         lci_pkg::OP_DIFF_MUL: begin
            mul_a = d_ff;
            mul_b = lci_pkg::sub_mod(xi_ff, rd_x_ff);
         end
         lci_pkg::OP_POWR_MUL: begin
            mul_a = r_ff;
            mul_b = base_ff;
         end
         lci_pkg::OP_POWB_MUL: begin
            mul_a = base_ff;
            mul_b = base_ff;
         end
         lci_pkg::OP_WT_MUL: begin
            mul_a = r_ff;
            mul_b = yi_ff;
         end
         lci_pkg::OP_SYN_U_MUL: begin
            mul_a = u_ff;
            mul_b = xi_ff;
         end
         lci_pkg::OP_SYN_W_MUL: begin
            mul_a = w_ff;
            mul_b = u_ff;
         end
         default: mul_start = 1'b0;
      endcase
   end

   lci_mulmod u_mulmod (
      .clock  (clock),
      .reset  (reset),
      .start  (mul_start),
      .a      (mul_a),
      .b      (mul_b),
      .done   (mul_done),
      .result (mul_res)
   );

   // hold read data between read strobes
   always_ff @(posedge clock) begin
      if (cmd.rd_en) begin
         rd_x_ff <= x_mem_ff[cmd.addr[5:0]];
         rd_y_ff <= y_mem_ff[cmd.addr[5:0]];
         rd_p_ff <= p_mem_ff[cmd.addr];
         rd_a_ff <= a_mem_ff[cmd.acc_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == lci_pkg::OP_STORE) begin
         x_mem_ff[cmd.addr[5:0]] <= lci_pkg::reduce_mod(x_value);
         y_mem_ff[cmd.addr[5:0]] <= lci_pkg::reduce_mod(y_value);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == lci_pkg::OP_NODE_WB) begin
         p_mem_ff[cmd.addr] <= lci_pkg::sub_mod(prev_ff, mul_res);
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.op == lci_pkg::OP_SYN_W_WB) begin
         a_mem_ff[cmd.acc_addr] <= lci_pkg::add_mod(acc_old, mul_res);
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         lci_pkg::OP_XI_LOAD: begin
            xi_ff   <= rd_x_ff;
            yi_ff   <= rd_y_ff;
            d_ff    <= 30'd1;
            prev_ff <= '0;
         end
         lci_pkg::OP_NODE_MUL: oldp_ff <= oldp;
         lci_pkg::OP_NODE_WB:  prev_ff <= oldp_ff;
         lci_pkg::OP_DIFF_WB:  d_ff <= mul_res;
         lci_pkg::OP_POW_INIT: begin
            base_ff <= d_ff;
            r_ff    <= 30'd1;
         end
         lci_pkg::OP_POWR_WB:  r_ff <= mul_res;
         lci_pkg::OP_POWB_WB:  base_ff <= mul_res;
         lci_pkg::OP_WT_WB: begin
            w_ff <= mul_res;
            u_ff <= '0;
         end
         lci_pkg::OP_SYN_U_WB: u_ff <= lci_pkg::add_mod(rd_p_ff, mul_res);
         lci_pkg::OP_OUT_LOAD: begin
            coef_ff <= rd_a_ff;
            pidx_ff <= cmd.acc_addr;
            last_ff <= cmd.out_last;
         end
         default: ;
      endcase
   end

   assign status.mul_done  = mul_done;
   assign coefficient      = coef_ff;
   assign power_index      = pidx_ff;
   assign last_coefficient = last_ff;
endmodule

// ----- rtl/lci_controller.sv -----
// Controller: sequences loading, node product, weights, synthetic division and output
`timescale 1ns / 1ps
module lci_controller (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_tvalid,
   input  logic                    req_tlast,
   output logic                    req_tready,
   output logic                    rsp_tvalid,
   input  logic                    rsp_tready,
   input  lci_pkg::lci_status_type status,
   output lci_pkg::lci_cmd_type    cmd
);
   lci_pkg::lci_state_type state_ff, state_in;
   logic [6:0] m_ff, m_in, i_ff, i_in, j_ff, j_in;
   logic [4:0] k_ff, k_in;
   logic       room, done;

   assign room = (m_ff < 7'(lci_pkg::MAX_POINTS));
   assign done = status.mul_done;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= lci_pkg::ST_IDLE;
         m_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         k_ff     <= '0;
      end else begin
         state_ff <= state_in;
         m_ff     <= m_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         k_ff     <= k_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      m_in     = m_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      k_in     = k_ff;
      case (state_ff)
         lci_pkg::ST_IDLE: begin
            if (req_tvalid) begin
               if (room) m_in = m_ff + 7'd1;
               if (req_tlast) begin
                  i_in     = '0;
                  state_in = lci_pkg::ST_N_XI;
               end
            end
         end
         lci_pkg::ST_N_XI:    state_in = lci_pkg::ST_N_XILAT;
         lci_pkg::ST_N_XILAT: begin
            j_in     = '0;
            state_in = lci_pkg::ST_N_RD;
         end
         lci_pkg::ST_N_RD:    state_in = lci_pkg::ST_N_MUL;
         lci_pkg::ST_N_MUL:   state_in = lci_pkg::ST_N_WAIT;
         lci_pkg::ST_N_WAIT: begin
            if (done) begin
               if (j_ff == i_ff + 7'd1) begin
                  if (i_ff + 7'd1 == m_ff) begin
                     i_in     = '0;
                     state_in = lci_pkg::ST_W_XI;
                  end else begin
                     i_in     = i_ff + 7'd1;
                     state_in = lci_pkg::ST_N_XI;
                  end
               end else begin
                  j_in     = j_ff + 7'd1;
                  state_in = lci_pkg::ST_N_RD;
               end
            end
         end
         lci_pkg::ST_W_XI:    state_in = lci_pkg::ST_W_XILAT;
         lci_pkg::ST_W_XILAT: begin
            j_in     = '0;
            state_in = lci_pkg::ST_W_RD;
         end
         lci_pkg::ST_W_RD: begin
            if (j_ff == m_ff) begin
               k_in     = '0;
               state_in = lci_pkg::ST_PW_R;
            end else if (j_ff == i_ff) begin
               j_in = j_ff + 7'd1;
            end else begin
               state_in = lci_pkg::ST_W_MUL;
            end
         end
         lci_pkg::ST_W_MUL:   state_in = lci_pkg::ST_W_WAIT;
         lci_pkg::ST_W_WAIT: begin
            if (done) begin
               j_in     = j_ff + 7'd1;
               state_in = lci_pkg::ST_W_RD;
            end
         end
         lci_pkg::ST_PW_R: begin
            state_in = lci_pkg::POW_EXP[k_ff] ? lci_pkg::ST_PW_RW : lci_pkg::ST_PW_B;
         end
         lci_pkg::ST_PW_RW:   if (done) state_in = lci_pkg::ST_PW_B;
         lci_pkg::ST_PW_B:    state_in = lci_pkg::ST_PW_BW;
         lci_pkg::ST_PW_BW: begin
            if (done) begin
               if (k_ff == 5'(lci_pkg::POW_BITS - 1)) begin
                  state_in = lci_pkg::ST_WT;
               end else begin
                  k_in     = k_ff + 5'd1;
                  state_in = lci_pkg::ST_PW_R;
               end
            end
         end
         lci_pkg::ST_WT:      state_in = lci_pkg::ST_WT_W;
         lci_pkg::ST_WT_W: begin
            if (done) begin
               j_in     = m_ff;
               state_in = lci_pkg::ST_S_RD;
            end
         end
         lci_pkg::ST_S_RD:    state_in = lci_pkg::ST_S_U;
         lci_pkg::ST_S_U:     state_in = lci_pkg::ST_S_UW;
         lci_pkg::ST_S_UW:    if (done) state_in = lci_pkg::ST_S_W;
         lci_pkg::ST_S_W:     state_in = lci_pkg::ST_S_WW;
         lci_pkg::ST_S_WW: begin
            if (done) begin
               if (j_ff == 7'd1) begin
                  if (i_ff + 7'd1 == m_ff) begin
                     j_in     = '0;
                     state_in = lci_pkg::ST_O_RD;
                  end else begin
                     i_in     = i_ff + 7'd1;
                     state_in = lci_pkg::ST_W_XI;
                  end
               end else begin
                  j_in     = j_ff - 7'd1;
                  state_in = lci_pkg::ST_S_RD;
               end
            end
         end
         lci_pkg::ST_O_RD:    state_in = lci_pkg::ST_O_LOAD;
         lci_pkg::ST_O_LOAD:  state_in = lci_pkg::ST_O_WAIT;
         lci_pkg::ST_O_WAIT: begin
            if (rsp_tready) begin
               if (j_ff + 7'd1 == m_ff) begin
                  m_in     = '0;
                  state_in = lci_pkg::ST_IDLE;
               end else begin
                  j_in     = j_ff + 7'd1;
                  state_in = lci_pkg::ST_O_RD;
               end
            end
         end
         default: state_in = lci_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      cmd          = '0;
      cmd.op       = lci_pkg::OP_NONE;
      cmd.oldp_sel = lci_pkg::OLDP_MEM;
      cmd.addr     = j_ff;
      cmd.acc_addr = 6'(j_ff - 7'd1);
      req_tready   = 1'b0;
      rsp_tvalid   = 1'b0;
      case (state_ff)
         lci_pkg::ST_IDLE: begin
            req_tready = 1'b1;
            cmd.addr   = m_ff;
            if (req_tvalid && room) cmd.op = lci_pkg::OP_STORE;
         end
         lci_pkg::ST_N_XI, lci_pkg::ST_W_XI: begin
            cmd.rd_en = 1'b1;
            cmd.addr  = i_ff;
         end
         lci_pkg::ST_N_XILAT, lci_pkg::ST_W_XILAT: cmd.op = lci_pkg::OP_XI_LOAD;
         lci_pkg::ST_N_RD: cmd.rd_en = 1'b1;
         lci_pkg::ST_N_MUL: begin
            cmd.op = lci_pkg::OP_NODE_MUL;
            // top entry starts empty; the first pass starts from the constant one
            if (j_ff == i_ff + 7'd1) begin
               cmd.oldp_sel = lci_pkg::OLDP_ZERO;
            end else if (i_ff == '0) begin
               cmd.oldp_sel = lci_pkg::OLDP_ONE;
            end
         end
         lci_pkg::ST_N_WAIT: if (done) cmd.op = lci_pkg::OP_NODE_WB;
         lci_pkg::ST_W_RD: begin
            if (j_ff == m_ff) begin
               cmd.op = lci_pkg::OP_POW_INIT;
            end else if (j_ff != i_ff) begin
               cmd.rd_en = 1'b1;
            end
         end
         lci_pkg::ST_W_MUL:  cmd.op = lci_pkg::OP_DIFF_MUL;
         lci_pkg::ST_W_WAIT: if (done) cmd.op = lci_pkg::OP_DIFF_WB;
         lci_pkg::ST_PW_R:   if (lci_pkg::POW_EXP[k_ff]) cmd.op = lci_pkg::OP_POWR_MUL;
         lci_pkg::ST_PW_RW:  if (done) cmd.op = lci_pkg::OP_POWR_WB;
         lci_pkg::ST_PW_B:   cmd.op = lci_pkg::OP_POWB_MUL;
         lci_pkg::ST_PW_BW:  if (done) cmd.op = lci_pkg::OP_POWB_WB;
         lci_pkg::ST_WT:     cmd.op = lci_pkg::OP_WT_MUL;
         lci_pkg::ST_WT_W:   if (done) cmd.op = lci_pkg::OP_WT_WB;
         lci_pkg::ST_S_RD:   cmd.rd_en = 1'b1;
         lci_pkg::ST_S_U:    cmd.op = lci_pkg::OP_SYN_U_MUL;
         lci_pkg::ST_S_UW:   if (done) cmd.op = lci_pkg::OP_SYN_U_WB;
         lci_pkg::ST_S_W:    cmd.op = lci_pkg::OP_SYN_W_MUL;
         lci_pkg::ST_S_WW: begin
            // first point overwrites whatever the accumulator held
            cmd.acc_zero = (i_ff == '0);
            if (done) cmd.op = lci_pkg::OP_SYN_W_WB;
         end
         lci_pkg::ST_O_RD: begin
            cmd.rd_en    = 1'b1;
            cmd.acc_addr = j_ff[5:0];
         end
         lci_pkg::ST_O_LOAD: begin
            cmd.op       = lci_pkg::OP_OUT_LOAD;
            cmd.acc_addr = j_ff[5:0];
            cmd.out_last = (j_ff + 7'd1 == m_ff);
         end
         lci_pkg::ST_O_WAIT: rsp_tvalid = 1'b1;
         default: ;
      endcase
   end
endmodule

// ----- rtl/lagrange_coefficient_interpolation.sv -----
// Top level: Lagrange interpolation modulo 998244353 over streamed points
//
// Input channel req_: one sample point per transfer, x and y residues in
// req_tdata, req_tlast on the final point of a set. Points past 64 are
// dropped; the flagged point still starts the interpolation.
// Non-final points are taken in one cycle each (one store write).
// After the final point, all work runs on a single four-stage Barrett
// multiplier, one product at a time: the node-product, difference-product
// and synthetic-division loops plus one Fermat inversion (58 products) per
// point. req_tready is low meanwhile. Result channel rsp_: m transfers,
// coefficient and power in rsp_tdata, ascending powers, rsp_tlast on the
// highest power. Each result is read from memory, loaded into the output
// register and held valid until the receiver takes it; a stall holds the
// current result, and the next result is read only after it is taken.
// After the last transfer the block is ready for a new set.
// Reset (synchronous) empties the point set and drops any run in progress.
`timescale 1ns / 1ps
module lagrange_coefficient_interpolation (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [63:0] req_tdata,   // x_value[29:0], y_value[59:30], zero pad
   input  logic        req_tlast,   // last_point
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // coefficient[29:0], power_index[35:30], zero pad
   output logic        rsp_tlast    // last_coefficient
);
   lci_pkg::lci_cmd_type    cmd;
   lci_pkg::lci_status_type status;
   logic [29:0] coefficient;
   logic [5:0]  power_index;

   lci_controller u_controller (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tlast  (req_tlast),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   lci_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .x_value          (req_tdata[29:0]),
      .y_value          (req_tdata[59:30]),
      .coefficient      (coefficient),
      .power_index      (power_index),
      .last_coefficient (rsp_tlast)
   );

   assign rsp_tdata = {4'b0, power_index, coefficient};
endmodule

// ----- rtl/lci_checker.sv -----
// Port-level checker for the interpolation block, bound to the top level
`timescale 1ns / 1ps
`include "lagrange_coefficient_interpolation_assert.svh"
module lci_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        req_tlast,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic        rsp_tlast
);
   `LCI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tlast))
   `LCI_ASSERT_NOW(a_one_side, clock, reset, rsp_tvalid, !req_tready)
   `LCI_ASSERT_NEXT(a_end_of_run, clock, reset, rsp_tvalid && rsp_tready && rsp_tlast, !rsp_tvalid && req_tready)
   `LCI_ASSERT_NOW(a_canonical, clock, reset, rsp_tvalid, rsp_tdata[29:0] < lci_pkg::MODP)
   `LCI_ASSERT_NEXT(a_busy_after_last, clock, reset, req_tvalid && req_tready && req_tlast, !req_tready)
endmodule

bind lagrange_coefficient_interpolation lci_checker u_lci_checker (.*);
